// ----- rtl/rtcm3rb_pkg.sv -----
// Shared types and constants for the RTCM3 frame ring buffer.
// Used by every module of the block but rtcm3rb_ram; depends on nothing else.

package rtcm3rb_pkg;

  localparam int SLOT_COUNT_DEF = 4;
  localparam int SLOT_BYTES_DEF = 1030;
  localparam int DATA_W = 8;
  localparam int LEN_W = 11;
  localparam int DROP_W = 8;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [DATA_W-1:0] SYNC_BYTE = 8'hD3;
  localparam logic [DATA_W-1:0] LEN_HI_MASK = 8'h03;
  localparam logic [LEN_W-1:0] CHECKSUM_BYTES = 11'd3;
  localparam logic [LEN_W-1:0] HEADER_BYTES = 11'd3;

  typedef enum logic {
    OP_SERIAL,
    OP_READ
  } op_t;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_BODY
  } phase_t;

  typedef struct packed {
    op_t op;
    logic [DATA_W-1:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic valid;
    item_t item;
  } head_t;

endpackage

// ----- rtl/rtcm3_frame_ring_buffer.sv -----
// Top level of the RTCM3 frame ring buffer.
// Depends on rtcm3rb_pkg, rtcm3rb_queue and rtcm3rb_back.

// Each request is either a received serial byte or a read of the next stored frame byte.
// The block takes one request per cycle, back to back, while its queue has room. A read's
// result passes through the queue stage, the registered read of the frame RAM and the
// output register. Serial bytes give no result and keep flowing while a read result waits
// at the output, unless a read is held at the head of the queue. Frames are stored whole
// in a ring of SLOT_COUNT slots of SLOT_BYTES bytes each; a frame that starts while every
// slot holds a complete frame is skipped and counted in dropped_count, which saturates
// at 255. The frame RAM needs no clearing, so the block is ready straight out of reset.

module rtcm3_frame_ring_buffer #(
  parameter int SLOT_COUNT = rtcm3rb_pkg::SLOT_COUNT_DEF,
  parameter int SLOT_BYTES = rtcm3rb_pkg::SLOT_BYTES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_command,
  input  logic [rtcm3rb_pkg::DATA_W-1:0]     in_rx_byte,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_byte_valid,
  output logic [rtcm3rb_pkg::DATA_W-1:0]     out_data_byte,
  output logic                               out_frame_last,
  output logic [rtcm3rb_pkg::DROP_W-1:0]     out_dropped_count
);

  rtcm3rb_pkg::head_t head;
  logic pop;

  rtcm3rb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_command(in_command),
    .in_rx_byte(in_rx_byte),
    .head      (head),
    .pop       (pop)
  );

  rtcm3rb_back #(
    .SLOT_COUNT(SLOT_COUNT),
    .SLOT_BYTES(SLOT_BYTES)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte_valid   (out_byte_valid),
    .out_data_byte    (out_data_byte),
    .out_frame_last   (out_frame_last),
    .out_dropped_count(out_dropped_count)
  );

endmodule

// ----- rtl/rtcm3rb_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Standalone; no package dependencies.

module rtcm3rb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4120
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/rtcm3rb_queue.sv -----
// Front end: accepts requests, tags them as serial byte or read, and queues them.
// Depends on rtcm3rb_pkg.

module rtcm3rb_queue (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_command,
  input  logic [rtcm3rb_pkg::DATA_W-1:0]     in_rx_byte,
  output rtcm3rb_pkg::head_t                 head,
  input  logic                               pop
);

  localparam int PTR_W = $clog2(rtcm3rb_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(rtcm3rb_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(rtcm3rb_pkg::QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(rtcm3rb_pkg::QUEUE_DEPTH);

  rtcm3rb_pkg::item_t entry_r [rtcm3rb_pkg::QUEUE_DEPTH];
  rtcm3rb_pkg::item_t new_item;
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic push;

  assign in_ready = (count_r != CNT_FULL);
  assign push = in_valid && in_ready;

  always_comb begin
    new_item.op = in_command ? rtcm3rb_pkg::OP_READ : rtcm3rb_pkg::OP_SERIAL;
    new_item.rx_byte = in_rx_byte;
    head.valid = (count_r != '0);
    head.item = entry_r[rd_ptr_r];
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= new_item;
    end
  end

endmodule

// ----- rtl/rtcm3rb_back.sv -----
// Back end: frame parser, slot ring bookkeeping, frame RAM and result pipeline.
// Depends on rtcm3rb_pkg and rtcm3rb_ram.

module rtcm3rb_back #(
  parameter int SLOT_COUNT = rtcm3rb_pkg::SLOT_COUNT_DEF,
  parameter int SLOT_BYTES = rtcm3rb_pkg::SLOT_BYTES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  rtcm3rb_pkg::head_t                 head,
  output logic                               pop,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_byte_valid,
  output logic [rtcm3rb_pkg::DATA_W-1:0]     out_data_byte,
  output logic                               out_frame_last,
  output logic [rtcm3rb_pkg::DROP_W-1:0]     out_dropped_count
);

  localparam int LEN_W = rtcm3rb_pkg::LEN_W;
  localparam int DATA_W = rtcm3rb_pkg::DATA_W;
  localparam int DROP_W = rtcm3rb_pkg::DROP_W;
  localparam int DEPTH = SLOT_COUNT * SLOT_BYTES;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int SLOT_W = $clog2(SLOT_COUNT);
  localparam int OFF_W = $clog2(SLOT_BYTES);
  localparam int STORED_W = $clog2(SLOT_COUNT + 1);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOT_COUNT - 1);
  localparam logic [STORED_W-1:0] STORED_FULL = STORED_W'(SLOT_COUNT);
  localparam logic [ADDR_W-1:0] SLOT_STRIDE = ADDR_W'(SLOT_BYTES);

  rtcm3rb_pkg::phase_t phase_r, phase_nxt;
  logic [LEN_W-1:0] remain_r, remain_nxt;
  logic skip_r, skip_nxt;
  logic [1:0] len_hi_r, len_hi_nxt;
  logic [OFF_W-1:0] wr_off_r, wr_off_nxt;
  logic [SLOT_W-1:0] wr_slot_r, wr_slot_nxt;
  logic [SLOT_W-1:0] rd_slot_r, rd_slot_nxt;
  logic [OFF_W-1:0] rd_off_r, rd_off_nxt;
  logic [STORED_W-1:0] stored_r, stored_nxt;
  logic [DROP_W-1:0] drop_r, drop_nxt;
  logic [LEN_W-1:0] flen_r [SLOT_COUNT];

  logic s1_v_r, s1_bv_r, s1_last_r;
  logic [DROP_W-1:0] s1_drop_r;
  logic out_valid_r, out_bv_r, out_last_r;
  logic [DATA_W-1:0] out_data_r;
  logic [DROP_W-1:0] out_drop_r;

  logic s1_adv, s1_free, is_read, exec, exec_read, exec_serial;
  logic ram_we, ram_re, flen_we, rd_bv, rd_last;
  logic [LEN_W-1:0] plen;
  logic [DATA_W-1:0] b;
  logic [DATA_W-1:0] rd_data;
  logic [ADDR_W-1:0] wr_addr, rd_addr;

  assign b = head.item.rx_byte;
  assign is_read = (head.item.op == rtcm3rb_pkg::OP_READ);
  assign s1_adv = s1_v_r && (!out_valid_r || out_ready);
  assign s1_free = !s1_v_r || s1_adv;
  assign exec = head.valid && (!is_read || s1_free);
  assign exec_read = exec && is_read;
  assign exec_serial = exec && !is_read;
  assign pop = exec;

  assign plen = {len_hi_r, b} + rtcm3rb_pkg::CHECKSUM_BYTES;
  assign wr_addr = ADDR_W'(wr_slot_r) * SLOT_STRIDE + ADDR_W'(wr_off_r);
  assign rd_addr = ADDR_W'(rd_slot_r) * SLOT_STRIDE + ADDR_W'(rd_off_r);

  always_comb begin
    phase_nxt = phase_r;
    remain_nxt = remain_r;
    skip_nxt = skip_r;
    len_hi_nxt = len_hi_r;
    wr_off_nxt = wr_off_r;
    wr_slot_nxt = wr_slot_r;
    rd_slot_nxt = rd_slot_r;
    rd_off_nxt = rd_off_r;
    stored_nxt = stored_r;
    drop_nxt = drop_r;
    ram_we = 1'b0;
    ram_re = 1'b0;
    flen_we = 1'b0;
    rd_bv = 1'b0;
    rd_last = 1'b0;
    if (exec_serial) begin
      unique case (phase_r)
        rtcm3rb_pkg::PH_HUNT: begin
          if (b == rtcm3rb_pkg::SYNC_BYTE) begin
            skip_nxt = (stored_r == STORED_FULL);
            if (skip_nxt && !(&drop_r)) begin
              drop_nxt = drop_r + 1'b1;
            end
            ram_we = !skip_nxt;
            wr_off_nxt = OFF_W'(1);
            phase_nxt = rtcm3rb_pkg::PH_LEN_HI;
          end
        end
        rtcm3rb_pkg::PH_LEN_HI: begin
          ram_we = !skip_r;
          len_hi_nxt = 2'(b & rtcm3rb_pkg::LEN_HI_MASK);
          wr_off_nxt = wr_off_r + 1'b1;
          phase_nxt = rtcm3rb_pkg::PH_LEN_LO;
        end
        rtcm3rb_pkg::PH_LEN_LO: begin
          ram_we = !skip_r;
          flen_we = !skip_r;
          remain_nxt = plen;
          wr_off_nxt = wr_off_r + 1'b1;
          phase_nxt = rtcm3rb_pkg::PH_BODY;
        end
        rtcm3rb_pkg::PH_BODY: begin
          ram_we = !skip_r;
          wr_off_nxt = wr_off_r + 1'b1;
          remain_nxt = remain_r - 1'b1;
          if (remain_r == LEN_W'(1)) begin
            if (!skip_r) begin
              wr_slot_nxt = (wr_slot_r == SLOT_LAST) ? '0 : wr_slot_r + 1'b1;
              stored_nxt = stored_r + 1'b1;
            end
            skip_nxt = 1'b0;
            wr_off_nxt = '0;
            phase_nxt = rtcm3rb_pkg::PH_HUNT;
          end
        end
        default: begin
          phase_nxt = rtcm3rb_pkg::PH_HUNT;
        end
      endcase
    end else if (exec_read && (stored_r != '0)) begin
      rd_bv = 1'b1;
      ram_re = 1'b1;
      if ((LEN_W + 1)'(rd_off_r) + 1'b1 >= {1'b0, flen_r[rd_slot_r]}) begin
        rd_last = 1'b1;
        rd_off_nxt = '0;
        rd_slot_nxt = (rd_slot_r == SLOT_LAST) ? '0 : rd_slot_r + 1'b1;
        stored_nxt = stored_r - 1'b1;
      end else begin
        rd_off_nxt = rd_off_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= rtcm3rb_pkg::PH_HUNT;
      remain_r <= '0;
      skip_r <= 1'b0;
      len_hi_r <= '0;
      wr_off_r <= '0;
      wr_slot_r <= '0;
      rd_slot_r <= '0;
      rd_off_r <= '0;
      stored_r <= '0;
      drop_r <= '0;
      s1_v_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      remain_r <= remain_nxt;
      skip_r <= skip_nxt;
      len_hi_r <= len_hi_nxt;
      wr_off_r <= wr_off_nxt;
      wr_slot_r <= wr_slot_nxt;
      rd_slot_r <= rd_slot_nxt;
      rd_off_r <= rd_off_nxt;
      stored_r <= stored_nxt;
      drop_r <= drop_nxt;
      if (s1_free) begin
        s1_v_r <= exec_read;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (flen_we) begin
      flen_r[wr_slot_r] <= plen + rtcm3rb_pkg::HEADER_BYTES;
    end
    if (exec_read) begin
      s1_bv_r <= rd_bv;
      s1_last_r <= rd_last;
      s1_drop_r <= drop_r;
    end
    if (s1_adv) begin
      out_bv_r <= s1_bv_r;
      out_data_r <= s1_bv_r ? rd_data : '0;
      out_last_r <= s1_last_r;
      out_drop_r <= s1_drop_r;
    end
  end

  rtcm3rb_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_frame_ram (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(wr_addr),
    .wr_data(b),
    .rd_en  (ram_re),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign out_valid = out_valid_r;
  assign out_byte_valid = out_bv_r;
  assign out_data_byte = out_data_r;
  assign out_frame_last = out_last_r;
  assign out_dropped_count = out_drop_r;

endmodule

// ----- rtl/rtcm3rb_checker.sv -----
// Port-level checks for the RTCM3 frame ring buffer, bound to its top level.
// Depends on rtcm3rb_pkg and rtcm3_frame_ring_buffer.

module rtcm3rb_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               in_command,
  input logic [rtcm3rb_pkg::DATA_W-1:0]     in_rx_byte,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic                               out_byte_valid,
  input logic [rtcm3rb_pkg::DATA_W-1:0]     out_data_byte,
  input logic                               out_frame_last,
  input logic [rtcm3rb_pkg::DROP_W-1:0]     out_dropped_count
);

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_command) && $stable(in_rx_byte))
    else $error("request changed while waiting");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte_valid) &&
      $stable(out_data_byte) && $stable(out_frame_last) && $stable(out_dropped_count))
    else $error("result changed while stalled");

  a_empty_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte_valid |-> !out_frame_last && out_data_byte == 8'h00)
    else $error("empty read result carries data");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("block not idle after reset");

  a_drop_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(out_valid) && $past(rst_n) |->
      out_dropped_count >= $past(out_dropped_count))
    else $error("dropped count decreased");

endmodule

bind rtcm3_frame_ring_buffer rtcm3rb_checker u_checker (.*);

// ----- tb/tb_rtcm3_frame_ring_buffer.sv -----
// Self-checking testbench for rtcm3_frame_ring_buffer: serial bytes and read requests in,
// every read result checked against a frame ring model in this file or a fixed directed result.
// Depends on rtcm3rb_pkg and the RTL of the block; needs nothing else to run.

module tb_rtcm3_frame_ring_buffer;

  localparam int DATA_W = rtcm3rb_pkg::DATA_W;
  localparam int DROP_W = rtcm3rb_pkg::DROP_W;
  localparam int LEN_W = rtcm3rb_pkg::LEN_W;
  localparam logic [DATA_W-1:0] SYNC_BYTE = rtcm3rb_pkg::SYNC_BYTE;
  localparam logic [DATA_W-1:0] LEN_HI_MASK = rtcm3rb_pkg::LEN_HI_MASK;
  localparam logic [LEN_W-1:0] CHECKSUM_BYTES = rtcm3rb_pkg::CHECKSUM_BYTES;
  localparam logic [LEN_W-1:0] HEADER_BYTES = rtcm3rb_pkg::HEADER_BYTES;
  localparam int SLOTS = rtcm3rb_pkg::SLOT_COUNT_DEF;
  localparam int SLOT_SIZE = rtcm3rb_pkg::SLOT_BYTES_DEF;
  localparam int STALL_LIMIT = 4000;
  localparam int TAIL_CYCLES = 8;
  localparam int MAX_PRINTS = 100;
  localparam int LONG_PAYLOAD = 260;
  localparam int FLOOD_FRAMES = 20;

  typedef struct packed {
    logic              byte_valid;
    logic [DATA_W-1:0] data_byte;
    logic              frame_last;
    logic [DROP_W-1:0] dropped_count;
  } read_result_t;

  typedef struct packed {
    rtcm3rb_pkg::op_t  op;
    logic [DATA_W-1:0] rx_byte;
    logic              fixed;
    read_result_t      result;
  } directed_row_t;

  typedef enum {
    DRAIN_FREE,
    DRAIN_COIN,
    DRAIN_SLOW,
    DRAIN_PERIODIC
  } drain_mode_t;

  localparam read_result_t NO_FRAME = '0;

  localparam directed_row_t STEPS [24] = '{
    '{rtcm3rb_pkg::OP_READ,   8'h3C, 1'b1, NO_FRAME},
    '{rtcm3rb_pkg::OP_SERIAL, 8'h00, 1'b0, NO_FRAME},
    '{rtcm3rb_pkg::OP_SERIAL, 8'hFF, 1'b0, NO_FRAME},
    '{rtcm3rb_pkg::OP_SERIAL, 8'hD3, 1'b0, NO_FRAME},
    '{rtcm3rb_pkg::OP_SERIAL, 8'h00, 1'b0, NO_FRAME},
    '{rtcm3rb_pkg::OP_SERIAL, 8'h00, 1'b0, NO_FRAME},
    '{rtcm3rb_pkg::OP_SERIAL, 8'hA5, 1'b0, NO_FRAME},
    '{rtcm3rb_pkg::OP_SERIAL, 8'h5A, 1'b0, NO_FRAME},
    '{rtcm3rb_pkg::OP_SERIAL, 8'h01, 1'b0, NO_FRAME},
    '{rtcm3rb_pkg::OP_READ,   8'hC3, 1'b1, '{1'b1, 8'hD3, 1'b0, 8'h00}},
    '{rtcm3rb_pkg::OP_READ,   8'h00, 1'b1, '{1'b1, 8'h00, 1'b0, 8'h00}},
    '{rtcm3rb_pkg::OP_READ,   8'hFF, 1'b1, '{1'b1, 8'h00, 1'b0, 8'h00}},
    '{rtcm3rb_pkg::OP_READ,   8'h00, 1'b1, '{1'b1, 8'hA5, 1'b0, 8'h00}},
    '{rtcm3rb_pkg::OP_READ,   8'h00, 1'b1, '{1'b1, 8'h5A, 1'b0, 8'h00}},
    '{rtcm3rb_pkg::OP_READ,   8'h00, 1'b1, '{1'b1, 8'h01, 1'b1, 8'h00}},
    '{rtcm3rb_pkg::OP_READ,   8'h00, 1'b1, NO_FRAME},
    '{rtcm3rb_pkg::OP_SERIAL, 8'hD3, 1'b0, NO_FRAME},
    '{rtcm3rb_pkg::OP_SERIAL, 8'hFC, 1'b0, NO_FRAME},
    '{rtcm3rb_pkg::OP_SERIAL, 8'h01, 1'b0, NO_FRAME},
    '{rtcm3rb_pkg::OP_SERIAL, 8'hD3, 1'b0, NO_FRAME},
    '{rtcm3rb_pkg::OP_SERIAL, 8'hFF, 1'b0, NO_FRAME},
    '{rtcm3rb_pkg::OP_SERIAL, 8'h00, 1'b0, NO_FRAME},
    '{rtcm3rb_pkg::OP_SERIAL, 8'h80, 1'b0, NO_FRAME},
    '{rtcm3rb_pkg::OP_READ,   8'h00, 1'b0, NO_FRAME}
  };

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              in_command = rtcm3rb_pkg::OP_SERIAL;
  logic [DATA_W-1:0] in_rx_byte = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_byte_valid;
  logic [DATA_W-1:0] out_data_byte;
  logic              out_frame_last;
  logic [DROP_W-1:0] out_dropped_count;

  logic [DATA_W-1:0]   ring_bytes [SLOTS][SLOT_SIZE];
  logic [LEN_W-1:0]    ring_len [SLOTS];
  rtcm3rb_pkg::phase_t ring_phase = rtcm3rb_pkg::PH_HUNT;
  logic [LEN_W-1:0]    ring_left = '0;
  logic [1:0]          ring_len_hi = '0;
  logic                ring_skip = 1'b0;
  int                  ring_wr = 0;
  int                  ring_rd = 0;
  int                  ring_rd_off = 0;
  int                  ring_count = 0;
  logic [DROP_W-1:0]   ring_drops = '0;

  read_result_t expected_reads [$];
  int           errors = 0;
  int           sent = 0;
  int           burst_left = 0;
  int           idle_cycles = 0;
  drain_mode_t  drain_mode = DRAIN_FREE;
  int           drain_hold = 0;

  rtcm3_frame_ring_buffer dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic ring_take(input rtcm3rb_pkg::op_t op, input logic [DATA_W-1:0] b,
                           output logic gives_result, output read_result_t r);
    int pos;
    r = '0;
    gives_result = (op == rtcm3rb_pkg::OP_READ);
    if (op == rtcm3rb_pkg::OP_READ) begin
      r.dropped_count = ring_drops;
      if (ring_count > 0) begin
        r.byte_valid = 1'b1;
        r.data_byte = ring_bytes[ring_rd][ring_rd_off];
        if (ring_rd_off + 1 >= ring_len[ring_rd]) begin
          r.frame_last = 1'b1;
          ring_rd_off = 0;
          ring_rd = (ring_rd + 1) % SLOTS;
          ring_count--;
        end else begin
          ring_rd_off++;
        end
      end
    end else begin
      case (ring_phase)
        rtcm3rb_pkg::PH_HUNT: begin
          if (b == SYNC_BYTE) begin
            ring_skip = (ring_count >= SLOTS);
            if (ring_skip && ring_drops != '1) ring_drops++;
            if (!ring_skip) ring_bytes[ring_wr][0] = b;
            ring_phase = rtcm3rb_pkg::PH_LEN_HI;
          end
        end
        rtcm3rb_pkg::PH_LEN_HI: begin
          if (!ring_skip) ring_bytes[ring_wr][1] = b;
          ring_len_hi = 2'(b & LEN_HI_MASK);
          ring_phase = rtcm3rb_pkg::PH_LEN_LO;
        end
        rtcm3rb_pkg::PH_LEN_LO: begin
          if (!ring_skip) ring_bytes[ring_wr][2] = b;
          ring_left = {ring_len_hi, b} + CHECKSUM_BYTES;
          if (!ring_skip) ring_len[ring_wr] = ring_left + HEADER_BYTES;
          ring_phase = rtcm3rb_pkg::PH_BODY;
        end
        default: begin
          if (!ring_skip) begin
            pos = ring_len[ring_wr] - ring_left;
            ring_bytes[ring_wr][pos] = b;
          end
          ring_left--;
          if (ring_left == 0) begin
            if (!ring_skip) begin
              ring_wr = (ring_wr + 1) % SLOTS;
              ring_count++;
            end
            ring_skip = 1'b0;
            ring_phase = rtcm3rb_pkg::PH_HUNT;
          end
        end
      endcase
    end
  endtask

  task automatic push_request(input rtcm3rb_pkg::op_t op, input logic [DATA_W-1:0] b,
                              input logic fixed, input read_result_t fixed_result);
    logic         gives_result;
    read_result_t r;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400)
                                               : $urandom_range(1, 16);
    end
    in_valid <= 1'b1;
    in_command <= op;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    sent++;
    ring_take(op, b, gives_result, r);
    if (gives_result) expected_reads.push_back(fixed ? fixed_result : r);
  endtask

  task automatic send_byte(input logic [DATA_W-1:0] b);
    push_request(rtcm3rb_pkg::OP_SERIAL, b, 1'b0, NO_FRAME);
  endtask

  task automatic send_read();
    push_request(rtcm3rb_pkg::OP_READ, DATA_W'($urandom), 1'b0, NO_FRAME);
  endtask

  function automatic logic [DATA_W-1:0] body_byte();
    return ($urandom_range(0, 9) == 0) ? SYNC_BYTE : DATA_W'($urandom);
  endfunction

  function automatic int pick_payload();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return $urandom_range(0, 8);
    if (r < 95) return $urandom_range(9, 60);
    return $urandom_range(61, 300);
  endfunction

  task automatic send_frame(input int payload, input logic with_reads);
    logic [9:0] plen;
    plen = payload[9:0];
    send_byte(SYNC_BYTE);
    send_byte({6'($urandom), plen[9:8]});
    send_byte(plen[7:0]);
    for (int i = 0; i < payload + 3; i++) begin
      if (with_reads && $urandom_range(0, 7) == 0) send_read();
      send_byte(body_byte());
    end
  endtask

  task automatic finish_open_frame();
    while (ring_phase != rtcm3rb_pkg::PH_HUNT) send_byte(DATA_W'($urandom));
  endtask

  task automatic run_mix(input int stop_at);
    int                pick;
    logic [DATA_W-1:0] b;
    while (sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        finish_open_frame();
        send_frame(pick_payload(), 1'b1);
      end else if (pick < 80) begin
        repeat ($urandom_range(1, 24)) send_read();
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 4)) begin
          b = DATA_W'($urandom);
          if (ring_phase == rtcm3rb_pkg::PH_HUNT && b == SYNC_BYTE) b = ~b;
          send_byte(b);
        end
      end else begin
        finish_open_frame();
        send_byte(SYNC_BYTE);
        send_byte(DATA_W'($urandom) & ~LEN_HI_MASK);
        send_byte(DATA_W'($urandom_range(0, 10)));
        repeat ($urandom_range(0, 3)) send_byte(body_byte());
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    errors++;
    if (errors <= MAX_PRINTS)
      $display("%0t: mismatch on %s, got %h, expected %h", $time, what, got, want);
  endtask

  always @(posedge clk) begin
    if (drain_hold == 0) begin
      drain_mode = drain_mode_t'($urandom_range(0, 3));
      drain_hold = $urandom_range(20, 200);
    end
    drain_hold--;
    case (drain_mode)
      DRAIN_FREE: out_ready <= 1'b1;
      DRAIN_COIN: out_ready <= 1'($urandom_range(0, 1));
      DRAIN_SLOW: out_ready <= ($urandom_range(0, 3) == 0);
      default:    out_ready <= (drain_hold % 3 != 0);
    endcase
  end

  always @(posedge clk) begin
    read_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_reads.size() == 0) begin
        report_mismatch("result with no read request pending", out_data_byte, '0);
      end else begin
        want = expected_reads.pop_front();
        if (out_byte_valid !== want.byte_valid)
          report_mismatch("byte_valid", out_byte_valid, want.byte_valid);
        if (out_data_byte !== want.data_byte)
          report_mismatch("data_byte", out_data_byte, want.data_byte);
        if (out_frame_last !== want.frame_last)
          report_mismatch("frame_last", out_frame_last, want.frame_last);
        if (out_dropped_count !== want.dropped_count)
          report_mismatch("dropped_count", out_dropped_count, want.dropped_count);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    foreach (STEPS[i])
      push_request(STEPS[i].op, STEPS[i].rx_byte, STEPS[i].fixed, STEPS[i].result);
    run_mix(250);
    finish_open_frame();
    while (ring_count < SLOTS) send_frame(pick_payload(), 1'b0);
    repeat (FLOOD_FRAMES) send_frame($urandom_range(0, 2), 1'b0);
    while (ring_count > 0) send_read();
    send_frame(LONG_PAYLOAD, 1'b1);
    while (ring_count > 0) send_read();
    run_mix(sent + 150);
    in_valid <= 1'b0;
    while (expected_reads.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- rtcm3_frame_ring_buffer.f -----
rtl/rtcm3rb_pkg.sv
rtl/rtcm3rb_ram.sv
rtl/rtcm3rb_queue.sv
rtl/rtcm3rb_back.sv
rtl/rtcm3_frame_ring_buffer.sv
rtl/rtcm3rb_checker.sv
tb/tb_rtcm3_frame_ring_buffer.sv
